// ----- hdl/dws_pkg.sv -----
// Shared types, codes and constants for the DMA writer supervisor.
// Used by every module in the hdl folder; depends on nothing else.
package dws_pkg;

    localparam int POINTER_BITS = 14;
    localparam int LEAD_SUM_BITS = 17;
    localparam int CMD_BITS = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    // Result word: 170 payload bits padded to whole bytes.
    localparam int OUT_BITS = 170;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [31:0] STALL_TIMEOUT_RESET = 32'd4000000;
    localparam logic [31:0] REARM_TIMEOUT_RESET = 32'd80000;
    localparam logic [15:0] LEAD_TARGET_RESET = 16'd8192;
    localparam logic [15:0] BLOCK_LIMIT_RESET = 16'd256;

    localparam logic [CMD_BITS-1:0] CMD_IDLE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_START = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_HALT = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_STALL_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REARM_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEAD_TARGET = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCK_LIMIT = 2'd3;

    typedef enum logic [2:0] {
        PH_READY     = 3'd0,
        PH_DISABLING = 3'd1,
        PH_STARTING  = 3'd2,
        PH_LEAD      = 3'd3,
        PH_RUNNING   = 3'd4,
        PH_RESTART   = 3'd5,
        PH_STOPPED   = 3'd6,
        PH_ERROR     = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        FAIL_CLEAR         = 3'd0,
        FAIL_LEAD_TIMEOUT  = 3'd1,
        FAIL_PTR_STALL     = 3'd2,
        FAIL_ACK_TIMEOUT   = 3'd3,
        FAIL_REARM_TIMEOUT = 3'd4
    } fail_t;

    typedef struct packed {
        logic [31:0] stall_timeout;
        logic [31:0] rearm_timeout;
        logic [15:0] lead_target;
        logic [15:0] block_limit;
    } cfg_t;

    typedef struct packed {
        logic [31:0] gap_last;
        logic [31:0] fill_max;
        logic [31:0] fill_min;
        logic [31:0] fill_last;
        logic [15:0] rearm_count;
        logic [15:0] block_count;
        fail_t       fail_reason;
        logic        sram_claim;
        logic        tx_clock_enable;
        logic        writer_start;
        logic        writer_enable;
        phase_t      run_state;
    } result_t;

endpackage

// ----- hdl/dws_cfg.sv -----
// Configuration register file for the DMA writer supervisor.
// Depends on dws_pkg for the register indexes, reset values and cfg_t.
module dws_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dws_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output dws_pkg::cfg_t                      cfg_o
);

    dws_pkg::cfg_t cfg_reg;
    dws_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg_o = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                dws_pkg::CFG_STALL_TIMEOUT: cfg_next.stall_timeout = cfg_data;
                dws_pkg::CFG_REARM_TIMEOUT: cfg_next.rearm_timeout = cfg_data;
                dws_pkg::CFG_LEAD_TARGET:   cfg_next.lead_target = cfg_data[15:0];
                dws_pkg::CFG_BLOCK_LIMIT:   cfg_next.block_limit = cfg_data[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stall_timeout <= dws_pkg::STALL_TIMEOUT_RESET;
            cfg_reg.rearm_timeout <= dws_pkg::REARM_TIMEOUT_RESET;
            cfg_reg.lead_target <= dws_pkg::LEAD_TARGET_RESET;
            cfg_reg.block_limit <= dws_pkg::BLOCK_LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hdl/dws_fsm.sv -----
// Supervisor state machine, tick counter, timers and fill statistics.
// Depends on dws_pkg; evaluates one registered input word per step.
module dws_fsm #(
    parameter int POINTER_BITS = dws_pkg::POINTER_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step_i,
    input  logic [dws_pkg::CMD_BITS-1:0] cmd_i,
    input  logic [POINTER_BITS-1:0]      ptr_i,
    input  logic                         done_i,
    input  logic                         enrb_i,
    input  dws_pkg::cfg_t                cfg_i,
    output dws_pkg::result_t             res_o
);

    localparam int LW = dws_pkg::LEAD_SUM_BITS;

    dws_pkg::phase_t phase_reg, phase_next;
    dws_pkg::fail_t  fail_reg, fail_next;
    logic [31:0] tick_reg, tick_next;
    logic [POINTER_BITS-1:0] prev_ptr_reg, prev_ptr_next;
    logic [LW-1:0] lead_sum_reg, lead_sum_next;
    logic [31:0] fill_start_reg, fill_start_next;
    logic [31:0] progress_reg, progress_next;
    logic [31:0] done_time_reg, done_time_next;
    logic [15:0] blocks_reg, blocks_next;
    logic [15:0] restarts_reg, restarts_next;
    logic [31:0] fill_last_reg, fill_last_next;
    logic [31:0] fill_min_reg, fill_min_next;
    logic [31:0] fill_max_reg, fill_max_next;
    logic [31:0] gap_reg, gap_next;

    logic pulse;
    logic ptr_full;
    logic [POINTER_BITS-1:0] ptr_diff;
    logic [LW-1:0] lead_acc;
    logic [31:0] since_done;
    logic [31:0] since_fill;
    logic [31:0] progress_eff;
    logic [31:0] fill_time;

    assign ptr_full = (ptr_i == {POINTER_BITS{1'b1}});
    assign ptr_diff = ptr_i - prev_ptr_reg;
    assign lead_acc = lead_sum_reg + LW'(ptr_diff);
    assign since_done = tick_reg - done_time_reg;
    assign since_fill = tick_reg - fill_start_reg;
    assign fill_time = since_fill;
    assign progress_eff = (ptr_i != prev_ptr_reg) ? tick_reg : progress_reg;

    // Next state and datapath for one tick.
    always_comb begin
        phase_next = phase_reg;
        fail_next = fail_reg;
        tick_next = tick_reg;
        prev_ptr_next = prev_ptr_reg;
        lead_sum_next = lead_sum_reg;
        fill_start_next = fill_start_reg;
        progress_next = progress_reg;
        done_time_next = done_time_reg;
        blocks_next = blocks_reg;
        restarts_next = restarts_reg;
        fill_last_next = fill_last_reg;
        fill_min_next = fill_min_reg;
        fill_max_next = fill_max_reg;
        gap_next = gap_reg;
        pulse = 1'b0;
        if (step_i) begin
            tick_next = tick_reg + 32'd1;
            case (phase_reg)
                dws_pkg::PH_DISABLING: begin
                    if (!enrb_i && !done_i) begin
                        phase_next = dws_pkg::PH_STARTING;
                        pulse = 1'b1;
                    end else if (since_done > cfg_i.rearm_timeout) begin
                        fail_next = dws_pkg::FAIL_ACK_TIMEOUT;
                        phase_next = dws_pkg::PH_ERROR;
                    end
                end
                dws_pkg::PH_STARTING: begin
                    if (enrb_i && !done_i) begin
                        if (blocks_reg == 16'd0) begin
                            prev_ptr_next = ptr_i;
                            lead_sum_next = '0;
                            fill_start_next = tick_reg;
                            phase_next = dws_pkg::PH_LEAD;
                        end else begin
                            phase_next = dws_pkg::PH_RESTART;
                        end
                    end else begin
                        fail_next = dws_pkg::FAIL_ACK_TIMEOUT;
                        phase_next = dws_pkg::PH_ERROR;
                    end
                end
                dws_pkg::PH_LEAD: begin
                    // An unchanged pointer adds zero, so the sum is always updated.
                    lead_sum_next = lead_acc;
                    prev_ptr_next = ptr_i;
                    if (since_fill > cfg_i.stall_timeout) begin
                        fail_next = dws_pkg::FAIL_LEAD_TIMEOUT;
                        phase_next = dws_pkg::PH_ERROR;
                    end else if (lead_acc >= LW'(cfg_i.lead_target)) begin
                        progress_next = tick_reg;
                        phase_next = dws_pkg::PH_RUNNING;
                    end
                end
                dws_pkg::PH_RUNNING: begin
                    if (cmd_i == dws_pkg::CMD_HALT) begin
                        phase_next = dws_pkg::PH_STOPPED;
                    end else begin
                        prev_ptr_next = ptr_i;
                        progress_next = progress_eff;
                        if (done_i && ptr_full) begin
                            fill_last_next = fill_time;
                            if (fill_time < fill_min_reg) begin
                                fill_min_next = fill_time;
                            end
                            if (fill_time > fill_max_reg) begin
                                fill_max_next = fill_time;
                            end
                            blocks_next = blocks_reg + 16'd1;
                            done_time_next = tick_reg;
                            phase_next = dws_pkg::PH_DISABLING;
                        end else if (tick_reg - progress_eff > cfg_i.stall_timeout) begin
                            fail_next = dws_pkg::FAIL_PTR_STALL;
                            phase_next = dws_pkg::PH_ERROR;
                        end
                    end
                end
                dws_pkg::PH_RESTART: begin
                    if (!ptr_full) begin
                        gap_next = since_done;
                        restarts_next = restarts_reg + 16'd1;
                        prev_ptr_next = ptr_i;
                        fill_start_next = tick_reg;
                        progress_next = tick_reg;
                        phase_next = (blocks_reg >= cfg_i.block_limit) ?
                                     dws_pkg::PH_STOPPED : dws_pkg::PH_RUNNING;
                    end else if (since_done > cfg_i.rearm_timeout) begin
                        fail_next = dws_pkg::FAIL_REARM_TIMEOUT;
                        phase_next = dws_pkg::PH_ERROR;
                    end
                end
                default: begin
                    // Ready, stopped and error: only a start command matters.
                    if (cmd_i == dws_pkg::CMD_START) begin
                        blocks_next = '0;
                        restarts_next = '0;
                        fill_last_next = '0;
                        fill_min_next = '1;
                        fill_max_next = '0;
                        gap_next = '0;
                        fail_next = dws_pkg::FAIL_CLEAR;
                        lead_sum_next = '0;
                        done_time_next = tick_reg;
                        phase_next = dws_pkg::PH_DISABLING;
                    end
                end
            endcase
        end
    end

    // Result fields, taken from the state after the tick.
    always_comb begin
        res_o.run_state = phase_next;
        res_o.writer_enable = phase_next inside {[dws_pkg::PH_STARTING:dws_pkg::PH_RESTART]};
        res_o.writer_start = pulse;
        res_o.tx_clock_enable = (phase_next inside {dws_pkg::PH_RUNNING, dws_pkg::PH_RESTART})
            || ((phase_next inside {dws_pkg::PH_DISABLING, dws_pkg::PH_STARTING})
                && (blocks_next != 16'd0));
        res_o.sram_claim = phase_next inside {[dws_pkg::PH_DISABLING:dws_pkg::PH_RESTART]};
        res_o.fail_reason = fail_next;
        res_o.block_count = blocks_next;
        res_o.rearm_count = restarts_next;
        res_o.fill_last = fill_last_next;
        res_o.fill_min = fill_min_next;
        res_o.fill_max = fill_max_next;
        res_o.gap_last = gap_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= dws_pkg::PH_READY;
            fail_reg <= dws_pkg::FAIL_CLEAR;
            tick_reg <= '0;
            prev_ptr_reg <= '0;
            lead_sum_reg <= '0;
            fill_start_reg <= '0;
            progress_reg <= '0;
            done_time_reg <= '0;
            blocks_reg <= '0;
            restarts_reg <= '0;
            fill_last_reg <= '0;
            fill_min_reg <= '1;
            fill_max_reg <= '0;
            gap_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            fail_reg <= fail_next;
            tick_reg <= tick_next;
            prev_ptr_reg <= prev_ptr_next;
            lead_sum_reg <= lead_sum_next;
            fill_start_reg <= fill_start_next;
            progress_reg <= progress_next;
            done_time_reg <= done_time_next;
            blocks_reg <= blocks_next;
            restarts_reg <= restarts_next;
            fill_last_reg <= fill_last_next;
            fill_min_reg <= fill_min_next;
            fill_max_reg <= fill_max_next;
            gap_reg <= gap_next;
        end
    end

    // The lead wait only happens on the first arm of a run.
    a_lead_first_arm: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == dws_pkg::PH_LEAD |-> blocks_reg == 16'd0)
        else $error("lead wait entered after a completed block");

    // Once a block has completed, the statistics are ordered.
    a_fill_order: assert property (@(posedge aclk) disable iff (!aresetn)
        blocks_reg != 16'd0 |-> fill_min_reg <= fill_max_reg)
        else $error("fill minimum exceeds fill maximum");

    // A stop command while running ends the run on that tick.
    a_stop_running: assert property (@(posedge aclk) disable iff (!aresetn)
        step_i && phase_reg == dws_pkg::PH_RUNNING && cmd_i == dws_pkg::CMD_HALT
        |=> phase_reg == dws_pkg::PH_STOPPED)
        else $error("stop command not honored while running");

    // The tick counter advances only with an evaluated word.
    a_tick_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_i |=> $stable(tick_reg))
        else $error("tick counter moved without a word");

endmodule

// ----- hdl/dws_out.sv -----
// Result register and master-side handshake for the DMA writer supervisor.
// Depends on dws_pkg for result_t and the result word width.
module dws_out (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load_i,
    input  dws_pkg::result_t                    res_i,
    output logic                                space_o,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dws_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);

    logic valid_reg, valid_next;
    dws_pkg::result_t res_reg;

    // The register can take a new word when empty or when its word leaves now.
    assign space_o = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata = {{(dws_pkg::OUT_TDATA_BITS - dws_pkg::OUT_BITS){1'b0}}, res_reg};

    always_comb begin
        valid_next = valid_reg;
        if (load_i) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            res_reg <= res_i;
        end
    end

endmodule

// ----- hdl/dws_in.sv -----
// Input word register for the DMA writer supervisor: captures one status word
// and holds it until the supervisor evaluates it. Depends on dws_pkg.
module dws_in #(
    parameter int POINTER_BITS = dws_pkg::POINTER_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept_i,
    input  logic                         step_i,
    input  logic [dws_pkg::CMD_BITS-1:0] cmd_i,
    input  logic [POINTER_BITS-1:0]      ptr_i,
    input  logic                         done_i,
    input  logic                         enrb_i,
    output logic                         valid_o,
    output logic [dws_pkg::CMD_BITS-1:0] cmd_o,
    output logic [POINTER_BITS-1:0]      ptr_o,
    output logic                         done_o,
    output logic                         enrb_o
);

    logic valid_reg, valid_next;
    logic [dws_pkg::CMD_BITS-1:0] cmd_reg;
    logic [POINTER_BITS-1:0] ptr_reg;
    logic done_reg;
    logic enrb_reg;

    assign valid_o = valid_reg;
    assign cmd_o = cmd_reg;
    assign ptr_o = ptr_reg;
    assign done_o = done_reg;
    assign enrb_o = enrb_reg;

    always_comb begin
        valid_next = valid_reg;
        if (accept_i) begin
            valid_next = 1'b1;
        end else if (step_i) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_i) begin
            cmd_reg <= cmd_i;
            ptr_reg <= ptr_i;
            done_reg <= done_i;
            enrb_reg <= enrb_i;
        end
    end

endmodule

// ----- hdl/dma_writer_supervisor_unit.sv -----
// DMA writer supervisor, top level: input register, state machine, result
// register and configuration registers. Depends on dws_pkg and the hdl dws_* modules.
//
// Usage: every timer tick the host sends one word on the s_ channel carrying
// a command, the writer's pointer, its done flag and its enable readback.
// For each word the block returns exactly one word on the m_ channel with
// the phase after that tick, the writer and clock controls, the failure code,
// the block and restart counts and the fill and gap times.
// A start command claims SRAM and cycles the writer's enable, a lead wait
// follows, then the run phase re-arms the writer on every done at the top
// of the ring. Stall, acknowledge and restart timeouts end in the error phase.
// An accepted word waits in the input register until the result register has
// room, then is evaluated into it; m_tvalid rises when the result is loaded.
// Throughput: one word per cycle while the receiver does not stall; the critical
// path is one 32-bit subtract and compare in the timeout checks.
// Stalls: s_tready stays high while the input register is empty or the
// result register is free or being emptied, so one word can wait on each
// side. A stalled receiver halts evaluation; no word is lost or repeated.
// Reset (aresetn low at a clock edge) puts the block in the ready phase with all
// counters cleared and the configuration registers at their defaults. The user must
// write configuration on the cfg_ channel only while no word is in flight (not enforced).
module dma_writer_supervisor_unit #(
    parameter int POINTER_BITS = dws_pkg::POINTER_BITS,
    localparam int IN_BITS = dws_pkg::CMD_BITS + POINTER_BITS + 2,
    localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata, from bit 0 up: command, write_pointer, done_flag,
    // enable_readback, zero padding.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [IN_TDATA_BITS-1:0]           s_tdata,
    // m_tdata, from bit 0 up: run_state, writer_enable, writer_start,
    // tx_clock_enable, sram_claim, fail_reason, block_count, rearm_count,
    // fill_last, fill_min, fill_max, gap_last, zero padding.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dws_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    // Configuration: index 0 stall_timeout, 1 rearm_timeout, 2 lead_target,
    // 3 block_limit.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dws_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int CW = dws_pkg::CMD_BITS;

    logic s_accept;
    logic step;
    logic out_space;
    logic in_valid;
    logic [CW-1:0] in_cmd;
    logic [POINTER_BITS-1:0] in_ptr;
    logic in_done;
    logic in_enrb;
    dws_pkg::cfg_t cfg;
    dws_pkg::result_t res;

    // A word is evaluated when one is held and the result register has room.
    assign step = in_valid && out_space;
    assign s_tready = !in_valid || out_space;
    assign s_accept = s_tvalid && s_tready;

    dws_in #(
        .POINTER_BITS(POINTER_BITS)
    ) u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept_i (s_accept),
        .step_i   (step),
        .cmd_i    (s_tdata[CW-1:0]),
        .ptr_i    (s_tdata[CW+POINTER_BITS-1:CW]),
        .done_i   (s_tdata[CW+POINTER_BITS]),
        .enrb_i   (s_tdata[CW+POINTER_BITS+1]),
        .valid_o  (in_valid),
        .cmd_o    (in_cmd),
        .ptr_o    (in_ptr),
        .done_o   (in_done),
        .enrb_o   (in_enrb)
    );

    dws_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    dws_fsm #(
        .POINTER_BITS(POINTER_BITS)
    ) u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_i  (step),
        .cmd_i   (in_cmd),
        .ptr_i   (in_ptr),
        .done_i  (in_done),
        .enrb_i  (in_enrb),
        .cfg_i   (cfg),
        .res_o   (res)
    );

    dws_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (step),
        .res_i    (res),
        .space_o  (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- dv/dws_checker.sv -----
// Scoreboard for the DMA writer supervisor: tracks configuration writes and input words,
// predicts one result word per input word and compares the result channel against it.
// Depends on dws_pkg for the result layout, phase and failure codes and register indexes.
module dws_checker #(
    parameter int IN_TDATA_BITS = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [IN_TDATA_BITS-1:0]           s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [dws_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [dws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dws_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                 mismatches,
    output int                                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB = dws_pkg::POINTER_BITS;
    localparam int CB = dws_pkg::CMD_BITS;
    localparam logic [PB-1:0] PTR_TOP = '1;

    dws_pkg::cfg_t                     settings;
    dws_pkg::phase_t                   phase_q;
    dws_pkg::fail_t                    fail_q;
    logic [31:0]                       tick_q;
    logic [PB-1:0]                     ptr_q;
    logic [dws_pkg::LEAD_SUM_BITS-1:0] lead_q;
    logic [31:0]                       fill_start_q;
    logic [31:0]                       progress_q;
    logic [31:0]                       done_q;
    logic [15:0]                       blocks_q;
    logic [15:0]                       restarts_q;
    logic [31:0]                       fill_last_q;
    logic [31:0]                       fill_min_q;
    logic [31:0]                       fill_max_q;
    logic [31:0]                       gap_q;

    dws_pkg::result_t expected_status[$];
    dws_pkg::result_t want;
    dws_pkg::result_t got;
    int               error_total = 0;

    function automatic void clear_run_stats();
        blocks_q    = '0;
        restarts_q  = '0;
        fill_last_q = '0;
        fill_min_q  = '1;
        fill_max_q  = '0;
        gap_q       = '0;
        fail_q      = dws_pkg::FAIL_CLEAR;
        lead_q      = '0;
    endfunction

    function automatic void reset_supervisor();
        settings.stall_timeout = dws_pkg::STALL_TIMEOUT_RESET;
        settings.rearm_timeout = dws_pkg::REARM_TIMEOUT_RESET;
        settings.lead_target   = dws_pkg::LEAD_TARGET_RESET;
        settings.block_limit   = dws_pkg::BLOCK_LIMIT_RESET;
        phase_q      = dws_pkg::PH_READY;
        tick_q       = '0;
        ptr_q        = '0;
        fill_start_q = '0;
        progress_q   = '0;
        done_q       = '0;
        clear_run_stats();
    endfunction

    function automatic void abort_run(input dws_pkg::fail_t code);
        fail_q  = code;
        phase_q = dws_pkg::PH_ERROR;
    endfunction

    // Advances the supervisor by one tick and returns the status it reports afterwards.
    function automatic dws_pkg::result_t supervise_tick(input logic [IN_TDATA_BITS-1:0] w);
        logic [CB-1:0]    cmd;
        logic [PB-1:0]    ptr;
        logic [PB-1:0]    step;
        logic             done;
        logic             en_rb;
        logic             pulse;
        logic [31:0]      now;
        logic [31:0]      elapsed;
        logic [31:0]      fill;
        dws_pkg::result_t r;
        cmd   = w[CB-1:0];
        ptr   = w[CB +: PB];
        done  = w[CB + PB];
        en_rb = w[CB + PB + 1];
        now   = tick_q;
        pulse = 1'b0;
        case (phase_q)
            dws_pkg::PH_DISABLING: begin
                elapsed = now - done_q;
                if (!en_rb && !done) begin
                    phase_q = dws_pkg::PH_STARTING;
                    pulse   = 1'b1;
                end else if (elapsed > settings.rearm_timeout) begin
                    abort_run(dws_pkg::FAIL_ACK_TIMEOUT);
                end
            end
            dws_pkg::PH_STARTING: begin
                if (en_rb && !done) begin
                    if (blocks_q == 16'd0) begin
                        ptr_q        = ptr;
                        lead_q       = '0;
                        fill_start_q = now;
                        phase_q      = dws_pkg::PH_LEAD;
                    end else begin
                        phase_q = dws_pkg::PH_RESTART;
                    end
                end else begin
                    abort_run(dws_pkg::FAIL_ACK_TIMEOUT);
                end
            end
            dws_pkg::PH_LEAD: begin
                if (ptr != ptr_q) begin
                    step   = ptr - ptr_q;
                    lead_q = lead_q + step;
                    ptr_q  = ptr;
                end
                elapsed = now - fill_start_q;
                if (elapsed > settings.stall_timeout) begin
                    abort_run(dws_pkg::FAIL_LEAD_TIMEOUT);
                end else if (lead_q >= settings.lead_target) begin
                    progress_q = now;
                    phase_q    = dws_pkg::PH_RUNNING;
                end
            end
            dws_pkg::PH_RUNNING: begin
                if (cmd == dws_pkg::CMD_HALT) begin
                    phase_q = dws_pkg::PH_STOPPED;
                end else begin
                    if (ptr != ptr_q) begin
                        ptr_q      = ptr;
                        progress_q = now;
                    end
                    elapsed = now - progress_q;
                    // A done at the top of the ring ends the block and skips the stall check.
                    if (done && ptr == PTR_TOP) begin
                        fill        = now - fill_start_q;
                        fill_last_q = fill;
                        if (fill < fill_min_q) fill_min_q = fill;
                        if (fill > fill_max_q) fill_max_q = fill;
                        blocks_q = blocks_q + 16'd1;
                        done_q   = now;
                        phase_q  = dws_pkg::PH_DISABLING;
                    end else if (elapsed > settings.stall_timeout) begin
                        abort_run(dws_pkg::FAIL_PTR_STALL);
                    end
                end
            end
            dws_pkg::PH_RESTART: begin
                elapsed = now - done_q;
                if (ptr != PTR_TOP) begin
                    gap_q        = elapsed;
                    restarts_q   = restarts_q + 16'd1;
                    ptr_q        = ptr;
                    fill_start_q = now;
                    progress_q   = now;
                    phase_q = (blocks_q >= settings.block_limit) ?
                              dws_pkg::PH_STOPPED : dws_pkg::PH_RUNNING;
                end else if (elapsed > settings.rearm_timeout) begin
                    abort_run(dws_pkg::FAIL_REARM_TIMEOUT);
                end
            end
            default: begin
                if (cmd == dws_pkg::CMD_START) begin
                    clear_run_stats();
                    done_q  = now;
                    phase_q = dws_pkg::PH_DISABLING;
                end
            end
        endcase
        tick_q = now + 32'd1;

        r.run_state       = phase_q;
        r.writer_enable   = phase_q >= dws_pkg::PH_STARTING && phase_q <= dws_pkg::PH_RESTART;
        r.writer_start    = pulse;
        r.tx_clock_enable = phase_q == dws_pkg::PH_RUNNING ||
                            phase_q == dws_pkg::PH_RESTART ||
                            ((phase_q == dws_pkg::PH_DISABLING ||
                              phase_q == dws_pkg::PH_STARTING) && blocks_q != 16'd0);
        r.sram_claim      = phase_q >= dws_pkg::PH_DISABLING && phase_q <= dws_pkg::PH_RESTART;
        r.fail_reason     = fail_q;
        r.block_count     = blocks_q;
        r.rearm_count     = restarts_q;
        r.fill_last       = fill_last_q;
        r.fill_min        = fill_min_q;
        r.fill_max        = fill_max_q;
        r.gap_last        = gap_q;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            error_total++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_supervisor();
            expected_status.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dws_pkg::CFG_STALL_TIMEOUT: settings.stall_timeout = cfg_data;
                    dws_pkg::CFG_REARM_TIMEOUT: settings.rearm_timeout = cfg_data;
                    dws_pkg::CFG_LEAD_TARGET:   settings.lead_target   = cfg_data[15:0];
                    dws_pkg::CFG_BLOCK_LIMIT:   settings.block_limit   = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_status.push_back(supervise_tick(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (expected_status.size() == 0) begin
                    $error("result word arrived with no input word pending");
                    error_total++;
                end else begin
                    want = expected_status.pop_front();
                    got  = m_tdata[dws_pkg::OUT_BITS-1:0];
                    check_field("run_state", 32'(want.run_state), 32'(got.run_state));
                    check_field("writer_enable", 32'(want.writer_enable),
                                32'(got.writer_enable));
                    check_field("writer_start", 32'(want.writer_start),
                                32'(got.writer_start));
                    check_field("tx_clock_enable", 32'(want.tx_clock_enable),
                                32'(got.tx_clock_enable));
                    check_field("sram_claim", 32'(want.sram_claim), 32'(got.sram_claim));
                    check_field("fail_reason", 32'(want.fail_reason), 32'(got.fail_reason));
                    check_field("block_count", 32'(want.block_count), 32'(got.block_count));
                    check_field("rearm_count", 32'(want.rearm_count), 32'(got.rearm_count));
                    check_field("fill_last", want.fill_last, got.fill_last);
                    check_field("fill_min", want.fill_min, got.fill_min);
                    check_field("fill_max", want.fill_max, got.fill_max);
                    check_field("gap_last", want.gap_last, got.gap_last);
                end
            end
        end
        mismatches  <= error_total;
        outstanding <= expected_status.size();
    end

endmodule

// ----- dv/tb.sv -----
// Top of the DMA writer supervisor testbench: clock, reset, stimulus and the verdict.
// Instantiates dma_writer_supervisor_unit and dws_checker; depends on dws_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB = dws_pkg::POINTER_BITS;
    localparam int CB = dws_pkg::CMD_BITS;
    localparam int IN_TDATA_BITS = ((CB + PB + 2 + 7) / 8) * 8;
    localparam logic [PB-1:0] PTR_TOP = '1;
    // Command code 3 has no name in the package; the block treats it as no command.
    localparam logic [CB-1:0] CMD_UNUSED = 2'd3;
    // Extra wait after the results have come back, to allow for the latency.
    localparam int LATENCY_CYCLES = 4;
    // Cycles without any accepted word after which the run is declared hung.
    localparam int HANG_LIMIT = 2000;

    logic aclk = 1'b0;
    logic aresetn;

    logic                                   s_tvalid;
    logic                                   s_tready;
    // s_tdata, from bit 0 up: command, write_pointer, done_flag, enable_readback, padding.
    logic [IN_TDATA_BITS-1:0]               s_tdata;
    logic                                   m_tvalid;
    logic                                   m_tready = 1'b0;
    // m_tdata, from bit 0 up: run_state, writer_enable, writer_start, tx_clock_enable,
    // sram_claim, fail_reason, block_count, rearm_count, fill_last, fill_min, fill_max,
    // gap_last, padding.
    logic [dws_pkg::OUT_TDATA_BITS-1:0]     m_tdata;
    logic                                   cfg_valid;
    logic                                   cfg_ready;
    logic [dws_pkg::CFG_INDEX_BITS-1:0]     cfg_index;
    logic [dws_pkg::CFG_DATA_BITS-1:0]      cfg_data;

    int mismatches;
    int outstanding;

    // Percentage of cycles in which each side holds off.
    int send_idle_pct = 15;
    int recv_idle_pct = 73;

    int quiet_cycles = 0;
    int words_sent = 0;

    // The stimulus keeps its own view of the writer's pointer and of the settings
    // so that most sequences are the ones a healthy writer would produce.
    logic [PB-1:0] wptr;
    logic [31:0]   stall_goal;
    int            lead_goal;
    int            block_goal;

    dma_writer_supervisor_unit uut (.*);

    dws_checker #(.IN_TDATA_BITS(IN_TDATA_BITS)) scoreboard (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // The receiver stalls at random; the rate changes from phase to phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Any accepted word on any channel proves the block is still alive.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= HANG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Offers one input word, with random hold-off first, and returns at the edge
    // where it is accepted. Valid is left high so back-to-back words stay contiguous.
    task automatic send_word(input logic [CB-1:0] cmd, input logic [PB-1:0] ptr,
                             input logic done, input logic en_rb);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_BITS'({en_rb, done, ptr, cmd});
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // Mostly no command, sometimes a start or the unused code, which an active
    // run ignores. A stop is mixed in only where it is ignored as well.
    function automatic logic [CB-1:0] quiet_cmd(input bit allow_stop);
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) return dws_pkg::CMD_IDLE;
        if (roll < 88) return dws_pkg::CMD_START;
        if (roll < 95 || !allow_stop) return CMD_UNUSED;
        return dws_pkg::CMD_HALT;
    endfunction

    // The writer drops its enable bit, then raises it again after the start pulse.
    // Now and then the readback lags, or the start check sees a bad status.
    task automatic cycle_enable();
        if ($urandom_range(3) == 0) begin
            send_word(dws_pkg::CMD_IDLE, wptr, 1'($urandom_range(1)), 1'b1);
        end
        send_word(quiet_cmd(1'b0), wptr, 1'b0, 1'b0);
        if ($urandom_range(9) == 0) begin
            send_word(dws_pkg::CMD_IDLE, wptr, 1'($urandom_range(1)), 1'b0);
        end else begin
            send_word(quiet_cmd(1'b0), wptr, 1'b0, 1'b1);
        end
    endtask

    // One complete run as a well-behaved writer would drive it: start, enable
    // cycling, lead wait, then blocks that end with done at the top of the ring
    // and are re-armed, until the block limit, a stop or a forced stall.
    task automatic writer_session();
        int blocks;
        int cap;
        int lead;
        int step;
        blocks = 0;
        cap    = $urandom_range(4, 1);
        send_word(dws_pkg::CMD_START, PB'($urandom), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
        cycle_enable();

        // Lead wait: the pointer advances in steps sized so that the target
        // takes a few ticks; a zero step is a tick without progress.
        lead = 0;
        do begin
            step = ($urandom_range(9) == 0) ? 0 :
                   $urandom_range((lead_goal < 49149) ? lead_goal / 3 + 1 : 16383, 1);
            wptr = wptr + PB'(step);
            lead += step;
            send_word(quiet_cmd(1'b1), wptr, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end while (lead < lead_goal);

        forever begin
            // Fill the block: jumps toward the top of the ring, with stalls.
            while (wptr != PTR_TOP) begin
                if ($urandom_range(19) == 0) begin
                    send_word(dws_pkg::CMD_HALT, wptr, 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                    return;
                end
                if (stall_goal < 40 && $urandom_range(29) == 0) begin
                    // Hold the pointer long enough for the stall watchdog to trip.
                    repeat (stall_goal + 2) send_word(dws_pkg::CMD_IDLE, wptr, 1'b0, 1'b1);
                    return;
                end
                if ($urandom_range(99) >= 15) begin
                    wptr = ($urandom_range(9) < 4) ? PTR_TOP :
                           wptr + PB'($urandom_range(PTR_TOP - wptr, 1));
                end
                send_word(quiet_cmd(1'b0), wptr,
                          (wptr != PTR_TOP) && ($urandom_range(9) == 0),
                          1'($urandom_range(1)));
            end
            if ($urandom_range(2) == 0) begin
                send_word(quiet_cmd(1'b0), PTR_TOP, 1'b0, 1'b1);
            end
            send_word(dws_pkg::CMD_IDLE, PTR_TOP, 1'b1, 1'($urandom_range(1)));
            blocks++;

            // Re-arm, then the pointer leaves the top of the ring after a short gap.
            cycle_enable();
            repeat ($urandom_range(2)) begin
                send_word(dws_pkg::CMD_IDLE, PTR_TOP, 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end
            wptr = PB'($urandom_range(255));
            send_word(dws_pkg::CMD_IDLE, wptr, 1'b0, 1'b1);
            if (blocks >= block_goal) return;
            if (blocks >= cap) begin
                send_word(dws_pkg::CMD_HALT, wptr, 1'($urandom_range(1)),
                          1'($urandom_range(1)));
                return;
            end
        end
    endtask

    // Random traffic: mostly complete runs, the rest short bursts of arbitrary words.
    task automatic random_traffic(input int count);
        int target;
        target = words_sent + count;
        while (words_sent < target) begin
            if ($urandom_range(99) < 85) begin
                writer_session();
            end else begin
                repeat ($urandom_range(5, 1)) begin
                    send_word(CB'($urandom_range(3)), PB'($urandom), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                end
            end
        end
    endtask

    // Stops sending and waits until every result has come back, plus the latency.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (LATENCY_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [dws_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [dws_pkg::CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Rewrites all four registers while the block is idle.
    task automatic reconfigure(input logic [31:0] stall, input logic [31:0] rearm,
                               input logic [15:0] lead, input logic [15:0] limit);
        drain();
        write_register(dws_pkg::CFG_STALL_TIMEOUT, stall);
        write_register(dws_pkg::CFG_REARM_TIMEOUT, rearm);
        write_register(dws_pkg::CFG_LEAD_TARGET, {16'd0, lead});
        write_register(dws_pkg::CFG_BLOCK_LIMIT, {16'd0, limit});
        cfg_valid  <= 1'b0;
        stall_goal = stall;
        lead_goal  = int'(lead);
        block_goal = int'(limit);
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= dws_pkg::CFG_STALL_TIMEOUT;
        cfg_data  <= '0;
        wptr       = '0;
        stall_goal = dws_pkg::STALL_TIMEOUT_RESET;
        lead_goal  = int'(dws_pkg::LEAD_TARGET_RESET);
        block_goal = int'(dws_pkg::BLOCK_LIMIT_RESET);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed sequence at the reset settings. Commands outside their phase.
        send_word(dws_pkg::CMD_IDLE, 14'h0000, 1'b0, 1'b0);
        send_word(dws_pkg::CMD_HALT, PTR_TOP, 1'b1, 1'b1);     // stop while ready is ignored
        send_word(CMD_UNUSED, 14'h2AAA, 1'b0, 1'b1);           // the unused code acts as none
        send_word(dws_pkg::CMD_START, 14'h1555, 1'b1, 1'b1);   // begin a run
        send_word(dws_pkg::CMD_START, 14'h0000, 1'b0, 1'b1);   // start while active; no ack yet
        send_word(dws_pkg::CMD_HALT, 14'h0000, 1'b0, 1'b0);    // disable ack; stop is ignored
        // First arm: the lead wait reaches exactly the reset target of 8192 words.
        send_word(dws_pkg::CMD_IDLE, 14'h0100, 1'b0, 1'b1);
        send_word(dws_pkg::CMD_HALT, 14'h1100, 1'b0, 1'b1);    // stop during lead wait is ignored
        send_word(dws_pkg::CMD_IDLE, 14'h2100, 1'b0, 1'b1);
        send_word(dws_pkg::CMD_IDLE, PTR_TOP, 1'b0, 1'b1);
        send_word(dws_pkg::CMD_IDLE, PTR_TOP, 1'b1, 1'b1);     // done at the top ends a block
        send_word(dws_pkg::CMD_IDLE, PTR_TOP, 1'b0, 1'b0);     // re-arm: disable ack
        send_word(dws_pkg::CMD_IDLE, PTR_TOP, 1'b0, 1'b1);     // re-arm: start check
        send_word(dws_pkg::CMD_IDLE, PTR_TOP, 1'b0, 1'b1);     // still waiting for the restart
        send_word(dws_pkg::CMD_IDLE, 14'h0000, 1'b0, 1'b1);    // pointer leaves the top
        send_word(dws_pkg::CMD_HALT, 14'h0000, 1'b0, 1'b1);    // stop while running
        // A new run from stopped clears the counters; the start check fails twice.
        send_word(dws_pkg::CMD_START, 14'h0000, 1'b0, 1'b0);
        send_word(dws_pkg::CMD_IDLE, 14'h0000, 1'b0, 1'b0);
        send_word(dws_pkg::CMD_IDLE, 14'h0000, 1'b0, 1'b0);    // readback still low
        send_word(dws_pkg::CMD_START, 14'h3000, 1'b0, 1'b0);   // restart from the error phase
        send_word(dws_pkg::CMD_IDLE, 14'h3000, 1'b0, 1'b0);
        send_word(dws_pkg::CMD_IDLE, 14'h3000, 1'b1, 1'b1);    // done during the start check

        // Short timeouts and a small target, so every failure shows up.
        reconfigure(32'd8, 32'd4, 16'd50, 16'd3);
        random_traffic(200);

        // Lowest legal settings: one-tick windows, a single block per run.
        reconfigure(32'd1, 32'd1, 16'd1, 16'd1);
        random_traffic(120);

        // From here on the sender stalls often and the receiver rarely.
        send_idle_pct = 73;
        recv_idle_pct = 15;

        // Highest settings: nothing times out and the lead needs large steps.
        reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        random_traffic(200);

        // All zero: every wait fails on its first tick without the awaited status, and the
        // lead wait fails even with it, so no block completes under the zero block limit.
        reconfigure(32'd0, 32'd0, 16'd0, 16'd0);
        random_traffic(80);

        // Last stretch without any idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;

        repeat (4) begin
            reconfigure($urandom_range(30, 1), $urandom_range(8, 1),
                        16'($urandom_range(40000, 1)), 16'($urandom_range(5, 1)));
            random_traffic(90);
        end

        drain();
        repeat (LATENCY_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
